// ----- hdl/dmc_pkg.sv -----
package dmc_pkg;

  // Default geometry
  localparam int unsigned DefLineCount   = 16;
  localparam int unsigned DefLineBytes   = 16;
  localparam int unsigned DefMemoryBytes = 2048;

  // Fixed field widths of the request and response
  localparam int unsigned AddrW = 11;
  localparam int unsigned DataW = 8;

  // Access kinds
  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } dmc_req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             hit;
    logic             wrote_back;
  } dmc_rsp_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_WBACK,
    ST_FILL,
    ST_ACCESS,
    ST_READ_OUT
  } dmc_state_e;

endpackage

// ----- hdl/dmc_ram.sv -----
module dmc_ram #(
  parameter  int unsigned DEPTH = 256,
  parameter  int unsigned WIDTH = 8,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dmc_ctrl.sv -----
module dmc_ctrl #(
  parameter  int unsigned LINE_COUNT   = dmc_pkg::DefLineCount,
  parameter  int unsigned LINE_BYTES   = dmc_pkg::DefLineBytes,
  parameter  int unsigned MEMORY_BYTES = dmc_pkg::DefMemoryBytes,
  localparam int unsigned LAW          = $clog2(LINE_COUNT * LINE_BYTES),
  localparam int unsigned MAW          = $clog2(MEMORY_BYTES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  dmc_pkg::dmc_req_t      req_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output dmc_pkg::dmc_rsp_t      rsp_o,
  // line data memory
  output logic                   ln_we_o,
  output logic [LAW-1:0]         ln_waddr_o,
  output logic [dmc_pkg::DataW-1:0] ln_wdata_o,
  output logic [LAW-1:0]         ln_raddr_o,
  input  logic [dmc_pkg::DataW-1:0] ln_rdata_i,
  // backing memory
  output logic                   bk_we_o,
  output logic [MAW-1:0]         bk_waddr_o,
  output logic [dmc_pkg::DataW-1:0] bk_wdata_o,
  output logic [MAW-1:0]         bk_raddr_o,
  input  logic [dmc_pkg::DataW-1:0] bk_rdata_i
);

  import dmc_pkg::*;

  localparam int unsigned OW = $clog2(LINE_BYTES);
  localparam int unsigned LW = $clog2(LINE_COUNT);
  localparam int unsigned TW = MAW - OW - LW;

  dmc_state_e state_q, state_d;
  dmc_req_t   req_q, req_d;
  dmc_rsp_t   rsp_q, rsp_d;
  logic       out_valid_q, out_valid_d;
  logic       hit_q, hit_d;
  logic       wb_q, wb_d;
  logic [MAW-1:0] init_q, init_d;
  logic [OW:0]    step_q, step_d;
  logic [LINE_COUNT-1:0] valid_q, valid_d;
  logic [LINE_COUNT-1:0] dirty_q, dirty_d;
  logic [TW-1:0]  tag_q [LINE_COUNT];
  logic           tag_we;

  logic [MAW-1:0] addr_m;
  logic [OW-1:0]  offset;
  logic [LW-1:0]  line;
  logic [TW-1:0]  tag;
  logic [TW-1:0]  old_tag;
  logic [OW-1:0]  step_lo;
  logic [OW-1:0]  step_prev;
  logic           step_last;
  logic           line_hit;

  // Split the request address, wrapped to the backing memory size
  assign addr_m    = MAW'(req_q.address);
  assign offset    = addr_m[OW-1:0];
  assign line      = addr_m[OW +: LW];
  assign tag       = addr_m[MAW-1 -: TW];
  assign old_tag   = tag_q[line];
  assign line_hit  = valid_q[line] && (old_tag == tag);
  assign step_lo   = step_q[OW-1:0];
  assign step_prev = OW'(step_q - 1'b1);
  assign step_last = (step_q == (OW+1)'(LINE_BYTES));

  // Next state, memory requests and result
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    out_valid_d = 1'b0;
    hit_d       = hit_q;
    wb_d        = wb_q;
    init_d      = init_q;
    step_d      = step_q;
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    tag_we      = 1'b0;
    ln_we_o     = 1'b0;
    ln_waddr_o  = {line, step_prev};
    ln_wdata_o  = bk_rdata_i;
    ln_raddr_o  = {line, step_lo};
    bk_we_o     = 1'b0;
    bk_waddr_o  = {old_tag, line, step_prev};
    bk_wdata_o  = ln_rdata_i;
    bk_raddr_o  = {tag, line, step_lo};

    unique case (state_q)
      // Sweep the backing memory with its reset pattern
      ST_INIT: begin
        bk_we_o    = 1'b1;
        bk_waddr_o = init_q;
        bk_wdata_o = DataW'(init_q);
        init_d     = init_q + 1'b1;
        if (init_q == MAW'(MEMORY_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        hit_d  = line_hit;
        wb_d   = 1'b0;
        step_d = '0;
        priority if (line_hit) begin
          state_d = ST_ACCESS;
        end else if (valid_q[line] && dirty_q[line]) begin
          state_d = ST_WBACK;
        end else begin
          state_d = ST_FILL;
        end
      end
      // Copy the victim line out, one byte behind the line read
      ST_WBACK: begin
        bk_we_o = (step_q != '0);
        if (step_last) begin
          step_d        = '0;
          wb_d          = 1'b1;
          dirty_d[line] = 1'b0;
          state_d       = ST_FILL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      // Fill the line from backing memory, one byte behind the read
      ST_FILL: begin
        ln_we_o = (step_q != '0);
        if (step_last) begin
          valid_d[line] = 1'b1;
          dirty_d[line] = 1'b0;
          tag_we        = 1'b1;
          state_d       = ST_ACCESS;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ACCESS: begin
        ln_raddr_o = {line, offset};
        if (req_q.action == ActWrite) begin
          ln_we_o       = 1'b1;
          ln_waddr_o    = {line, offset};
          ln_wdata_o    = req_q.write_data;
          dirty_d[line] = 1'b1;
          out_valid_d   = 1'b1;
          rsp_d         = '{read_data: req_q.write_data, hit: hit_q, wrote_back: wb_q};
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_READ_OUT;
        end
      end
      ST_READ_OUT: begin
        out_valid_d = 1'b1;
        rsp_d       = '{read_data: ln_rdata_i, hit: hit_q, wrote_back: wb_q};
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      dirty_q     <= '0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    hit_q <= hit_d;
    wb_q  <= wb_d;
    if (tag_we) begin
      tag_q[line] <= tag;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = out_valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ----- hdl/direct_mapped_cache_unit.sv -----
// Direct-mapped write-back cache in front of a byte-wide backing memory.
// An access passes lookup, then on a miss a write-back of a dirty victim and a line fill,
// then the line access; a read takes an extra read-out state before the result strobe.
// Line transfers move one byte a cycle; busy drops with the strobe, so a new access is
// taken only after the current one completes.
// After reset busy stays high while the backing memory is loaded.
module direct_mapped_cache_unit #(
  parameter int unsigned LINE_COUNT   = dmc_pkg::DefLineCount,
  parameter int unsigned LINE_BYTES   = dmc_pkg::DefLineBytes,
  parameter int unsigned MEMORY_BYTES = dmc_pkg::DefMemoryBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  dmc_pkg::dmc_req_t req_i,
  output logic              busy,
  output logic              valid_o,
  output dmc_pkg::dmc_rsp_t rsp_o
);

  import dmc_pkg::*;

  localparam int unsigned LAW = $clog2(LINE_COUNT * LINE_BYTES);
  localparam int unsigned MAW = $clog2(MEMORY_BYTES);

  logic             ln_we;
  logic [LAW-1:0]   ln_waddr;
  logic [DataW-1:0] ln_wdata;
  logic [LAW-1:0]   ln_raddr;
  logic [DataW-1:0] ln_rdata;
  logic             bk_we;
  logic [MAW-1:0]   bk_waddr;
  logic [DataW-1:0] bk_wdata;
  logic [MAW-1:0]   bk_raddr;
  logic [DataW-1:0] bk_rdata;

  dmc_ctrl #(
    .LINE_COUNT  (LINE_COUNT),
    .LINE_BYTES  (LINE_BYTES),
    .MEMORY_BYTES(MEMORY_BYTES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .busy_o    (busy),
    .valid_o   (valid_o),
    .rsp_o     (rsp_o),
    .ln_we_o   (ln_we),
    .ln_waddr_o(ln_waddr),
    .ln_wdata_o(ln_wdata),
    .ln_raddr_o(ln_raddr),
    .ln_rdata_i(ln_rdata),
    .bk_we_o   (bk_we),
    .bk_waddr_o(bk_waddr),
    .bk_wdata_o(bk_wdata),
    .bk_raddr_o(bk_raddr),
    .bk_rdata_i(bk_rdata)
  );

  // Line data store
  dmc_ram #(
    .DEPTH(LINE_COUNT * LINE_BYTES),
    .WIDTH(DataW)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ln_we),
    .waddr_i(ln_waddr),
    .wdata_i(ln_wdata),
    .raddr_i(ln_raddr),
    .rdata_o(ln_rdata)
  );

  // Backing memory
  dmc_ram #(
    .DEPTH(MEMORY_BYTES),
    .WIDTH(DataW)
  ) u_back_ram (
    .clk_i  (clk_i),
    .we_i   (bk_we),
    .waddr_i(bk_waddr),
    .wdata_i(bk_wdata),
    .raddr_i(bk_raddr),
    .rdata_o(bk_rdata)
  );

endmodule

// ----- hdl/dmc_checker.sv -----
module dmc_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              valid_o,
  input dmc_pkg::dmc_rsp_t rsp_o
);

  // A result never shows while an access is still in flight
  a_result_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  // Results are single-cycle strobes
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held two cycles");

  // An accepted transfer makes the unit busy and produces no result at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !valid_o))
    else $error("accepted transfer did not start an access");

  // A write-back only happens on a miss
  a_wb_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.wrote_back) |-> !rsp_o.hit)
    else $error("write-back reported on a hit");

endmodule

bind direct_mapped_cache_unit dmc_port_checker u_dmc_port_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .valid_o(valid_o),
  .rsp_o  (rsp_o)
);
